>>> design/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types, constants and coefficient tables of the Adams-Bashforth
// stepper.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int STATE_DIM   = 16;
  localparam int HIST_DEPTH  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int SV_AW    = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int ROW_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HIST_AW  = ROW_W + SV_AW;
  localparam int HIST_WORDS = 2 ** HIST_AW;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_INVAL = 2'd2;

  localparam logic [2:0] ORDER_ONE = 3'd1;
  localparam logic [2:0] ORDER_TOP = 3'd4;
  localparam logic [2:0] ORDER_RST = 3'd4;
  localparam logic [2:0] HIST_LIM  = 3'(HIST_DEPTH);

  // ceil(2^20 / 3): exact quotient for dividends below 2^18
  localparam logic [18:0] RECIP3 = 19'd349526;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_STEP,
    CMD_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [3:0]         idx;
    logic               last;
    logic signed [31:0] val;
    logic [31:0]        h;
    logic [2:0]         ord;
    logic [ROW_W-1:0]   row;
  } cmd_t;

  function automatic logic [2:0] order_limit(input logic [2:0] m);
    logic [2:0] l;
    l = m;
    if (l == 3'd0) l = ORDER_ONE;
    if (l > ORDER_TOP) l = ORDER_TOP;
    if (l > HIST_LIM) l = HIST_LIM;
    return l;
  endfunction

  // coefficients scaled by 24, tap 0 is the newest derivative
  function automatic logic signed [7:0] ab_coef(input logic [2:0] ord,
                                                input logic [1:0] tap);
    logic signed [7:0] c;
    c = '0;
    unique case ({ord, tap})
      {3'd1, 2'd0}: c = 8'sd24;
      {3'd2, 2'd0}: c = 8'sd36;
      {3'd2, 2'd1}: c = -8'sd12;
      {3'd3, 2'd0}: c = 8'sd46;
      {3'd3, 2'd1}: c = -8'sd32;
      {3'd3, 2'd2}: c = 8'sd10;
      {3'd4, 2'd0}: c = 8'sd55;
      {3'd4, 2'd1}: c = -8'sd59;
      {3'd4, 2'd2}: c = 8'sd37;
      {3'd4, 2'd3}: c = -8'sd9;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> design/adams_bashforth_stepper_unit.sv
// ----------------------------------------------------------------------------
// adams_bashforth_stepper_unit
// Explicit Adams-Bashforth integrator, orders 1 to 4, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Every input beat gives one result beat, in order. Load, invalidate and
// unused requests pass from the execution unit straight to the output; a
// step element takes one history memory read per extra tap through a single
// multiply-accumulate and a four-digit serial divide by 24.
// A two-entry command queue lets the input side take beats while the
// execution unit is busy, and the output register holds a finished beat
// while the next one is worked on. The max_order register is written through
// the cfg port and restarts the order at one.
// ----------------------------------------------------------------------------
module adams_bashforth_stepper_unit import abs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         element_index_i,
  input  logic               last_element_i,
  input  logic signed [31:0] value_i,
  input  logic [31:0]        step_size_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] state_value_o,
  output logic [3:0]         out_index_o,
  output logic               out_last_o,
  output logic [2:0]         order_used_o,
  output logic               saturated_o
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic q_full;
  logic q_empty;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  abs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .q_full_i       (q_full),
    .req_type_i     (req_type_i),
    .element_index_i(element_index_i),
    .last_element_i (last_element_i),
    .value_i        (value_i),
    .step_size_i    (step_size_i),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  abs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  abs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .state_value_o(state_value_o),
    .out_index_o  (out_index_o),
    .out_last_o   (out_last_o),
    .order_used_o (order_used_o),
    .saturated_o  (saturated_o)
  );

`ifndef NO_ASSERTIONS
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_used_o != 3'd0) && (order_used_o <= ORDER_TOP))
    else $error("order_used out of range");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (state_value_o == 32'sh7FFF_FFFF) || (state_value_o == 32'sh8000_0000))
    else $error("saturated result not on a rail");

  a_push_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !pop |=> in_stall_o)
    else $error("queue full but input not stalled");
`endif

endmodule

>>> design/abs_ram.sv
// ----------------------------------------------------------------------------
// abs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/abs_front.sv
// ----------------------------------------------------------------------------
// abs_front
// Accepts items, settles the Adams order of each step and keeps the order,
// ring row and step size control state. Emits one command per item.
// ----------------------------------------------------------------------------
module abs_front import abs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               q_full_i,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         element_index_i,
  input  logic               last_element_i,
  input  logic signed [31:0] value_i,
  input  logic [31:0]        step_size_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [2:0]       max_order_q, max_order_d;
  logic [2:0]       cur_order_q, cur_order_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [31:0]      prev_h_q, prev_h_d;

  logic       idx_ok;
  logic [2:0] lim;
  logic [2:0] step_ord;
  logic [2:0] next_ord;

  assign push_o = in_valid_i && !q_full_i;
  assign idx_ok = 32'(element_index_i) < STATE_DIM;
  assign lim    = order_limit(max_order_q);

  always_comb begin
    step_ord = (step_size_i != prev_h_q) ? ORDER_ONE : cur_order_q;
    if (step_ord == 3'd0) step_ord = ORDER_ONE;
    if (step_ord > lim) step_ord = lim;
    next_ord = step_ord + 3'd1;
    if (next_ord > lim) next_ord = lim;
  end

  always_comb begin
    max_order_d = max_order_q;
    cur_order_d = cur_order_q;
    row_d       = row_q;
    prev_h_d    = prev_h_q;

    cmd_o.kind = CMD_ZERO;
    cmd_o.idx  = element_index_i;
    cmd_o.last = last_element_i;
    cmd_o.val  = value_i;
    cmd_o.h    = step_size_i;
    cmd_o.ord  = cur_order_q;
    cmd_o.row  = row_q;

    unique case (req_type_i)
      REQ_LOAD: begin
        if (idx_ok) cmd_o.kind = CMD_LOAD;
      end
      REQ_STEP: begin
        cmd_o.ord = step_ord;
        if (idx_ok) cmd_o.kind = CMD_STEP;
        if (push_o && last_element_i) begin
          cur_order_d = next_ord;
          row_d       = (32'(row_q) == HIST_DEPTH - 1) ? '0 : row_q + 1'b1;
          prev_h_d    = step_size_i;
        end
      end
      REQ_INVAL: begin
        cmd_o.ord = ORDER_ONE;
        if (push_o) begin
          cur_order_d = ORDER_ONE;
          prev_h_d    = '0;
        end
      end
      default: begin
      end
    endcase

    if (cfg_valid_i) begin
      max_order_d = cfg_data_i;
      cur_order_d = ORDER_ONE;
      prev_h_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_order_q <= ORDER_RST;
      cur_order_q <= ORDER_ONE;
      row_q       <= '0;
      prev_h_q    <= '0;
    end else begin
      max_order_q <= max_order_d;
      cur_order_q <= cur_order_d;
      row_q       <= row_d;
      prev_h_q    <= prev_h_d;
    end
  end

endmodule

>>> design/abs_queue.sv
// ----------------------------------------------------------------------------
// abs_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module abs_queue import abs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = 32'(count_q) == QUEUE_DEPTH;
  assign empty_o = count_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> design/abs_back.sv
// ----------------------------------------------------------------------------
// abs_back
// Executes commands: state and history memories, coefficient
// multiply-accumulate, scale by h, digit-serial divide by 24, saturation
// and the output register.
// ----------------------------------------------------------------------------
module abs_back import abs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  cmd_t               q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] state_value_o,
  output logic [3:0]         out_index_o,
  output logic               out_last_o,
  output logic [2:0]         order_used_o,
  output logic               saturated_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAC,
    ST_SCALE,
    ST_SUM,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } back_state_e;

  localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

  back_state_e        state_q;
  cmd_t               cmd_q;
  logic signed [42:0] acc_q;
  logic [2:0]         tap_q;
  logic [57:0]        ph_q, pl_q;
  logic               neg_q;
  logic [63:0]        div_q;
  logic [63:0]        quo_q;
  logic [1:0]         rem_q;
  logic [1:0]         dcnt_q;
  logic signed [31:0] res_q;
  logic               sat_q;

  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic [3:0]         out_index_q;
  logic               out_last_q;
  logic [2:0]         out_ord_q;
  logic               out_sat_q;
  logic               out_load;

  logic [SV_AW-1:0]   sv_addr;
  logic               sv_we;
  logic [31:0]        sv_wdata;
  logic [31:0]        sv_rdata;
  logic               hist_we;
  logic               hist_re;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [31:0]        hist_rdata;
  logic [1:0]         rd_tap;

  logic signed [39:0] mac_prod;
  logic [41:0]        mag;
  logic [57:0]        t_sum;
  logic [17:0]        dx;
  logic [36:0]        dprod;
  logic [15:0]        qd;
  logic [17:0]        drem;
  logic signed [65:0] delta;
  logic signed [65:0] nv;
  logic signed [31:0] nv_sat;
  logic               nv_clip;

  function automatic logic [ROW_W-1:0] ring_back(input logic [ROW_W-1:0] row,
                                                 input logic [1:0] tap);
    logic [2:0] r;
    r = 3'(row);
    if (r >= 3'(tap)) r = r - 3'(tap);
    else r = r + HIST_LIM - 3'(tap);
    return ROW_W'(r);
  endfunction

  assign sv_addr = SV_AW'(cmd_q.idx);
  assign pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  assign rd_tap     = (state_q == ST_EXEC) ? 2'd1 : 2'(tap_q + 3'd1);
  assign hist_we    = (state_q == ST_EXEC) && (cmd_q.kind == CMD_STEP);
  assign hist_re    = (state_q == ST_EXEC) || (state_q == ST_MAC);
  assign hist_waddr = {cmd_q.row, sv_addr};
  assign hist_raddr = {ring_back(cmd_q.row, rd_tap), sv_addr};

  assign sv_we    = ((state_q == ST_EXEC) && (cmd_q.kind == CMD_LOAD)) ||
                    (state_q == ST_FIN);
  assign sv_wdata = (state_q == ST_FIN) ? nv_sat : cmd_q.val;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  abs_ram #(
    .WIDTH(32),
    .DEPTH(STATE_DIM)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (sv_we),
    .waddr_i(sv_addr),
    .wdata_i(sv_wdata),
    .re_i   (hist_we),
    .raddr_i(sv_addr),
    .rdata_o(sv_rdata)
  );

  abs_ram #(
    .WIDTH(32),
    .DEPTH(HIST_WORDS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(cmd_q.val),
    .re_i   (hist_re),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  always_comb begin
    if (state_q == ST_EXEC) begin
      mac_prod = ab_coef(cmd_q.ord, 2'd0) * cmd_q.val;
    end else begin
      mac_prod = ab_coef(cmd_q.ord, tap_q[1:0]) * $signed(hist_rdata);
    end
  end

  assign mag   = acc_q[42] ? 42'(-acc_q) : 42'(acc_q);
  assign t_sum = ph_q + (pl_q >> 16);

  assign dx    = {rem_q, div_q[63:48]};
  assign dprod = 37'(dx) * 37'(RECIP3);
  assign qd    = dprod[35:20];
  assign drem  = dx - 18'(qd) * 18'd3;

  always_comb begin
    delta   = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    nv      = 66'($signed(sv_rdata)) + delta;
    nv_sat  = 32'(nv);
    nv_clip = 1'b0;
    if (nv > SAT_MAX) begin
      nv_sat  = 32'(SAT_MAX);
      nv_clip = 1'b1;
    end else if (nv < SAT_MIN) begin
      nv_sat  = 32'(SAT_MIN);
      nv_clip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      acc_q       <= '0;
      tap_q       <= '0;
      ph_q        <= '0;
      pl_q        <= '0;
      neg_q       <= 1'b0;
      div_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      res_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_index_q <= '0;
      out_last_q  <= 1'b0;
      out_ord_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            cmd_q   <= q_head_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          sat_q <= 1'b0;
          unique case (cmd_q.kind)
            CMD_LOAD: begin
              res_q   <= cmd_q.val;
              state_q <= ST_OUT;
            end
            CMD_STEP: begin
              acc_q   <= 43'(mac_prod);
              tap_q   <= 3'd1;
              state_q <= ST_MAC;
            end
            default: begin
              res_q   <= '0;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_MAC: begin
          if (tap_q < cmd_q.ord) begin
            acc_q <= acc_q + 43'(mac_prod);
            tap_q <= tap_q + 3'd1;
          end else begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          ph_q    <= 58'(mag) * 58'(cmd_q.h[31:16]);
          pl_q    <= 58'(mag) * 58'(cmd_q.h[15:0]);
          neg_q   <= acc_q[42];
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          div_q   <= 64'(t_sum >> 3);
          quo_q   <= '0;
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          quo_q  <= {quo_q[47:0], qd};
          div_q  <= {div_q[47:0], 16'h0000};
          rem_q  <= drem[1:0];
          dcnt_q <= dcnt_q + 2'd1;
          if (dcnt_q == 2'd3) state_q <= ST_FIN;
        end
        ST_FIN: begin
          res_q   <= nv_sat;
          sat_q   <= nv_clip;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_value_q <= res_q;
            out_index_q <= cmd_q.idx;
            out_last_q  <= cmd_q.last;
            out_ord_q   <= cmd_q.ord;
            out_sat_q   <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign state_value_o = out_value_q;
  assign out_index_o   = out_index_q;
  assign out_last_o    = out_last_q;
  assign order_used_o  = out_ord_q;
  assign saturated_o   = out_sat_q;

endmodule

>>> tb/adams_bashforth_stepper_unit_tb.sv
// ----------------------------------------------------------------------------
// adams_bashforth_stepper_unit_tb
// Self-checking bench for the Adams-Bashforth stepper. A short table of
// directed beats covers the extremes, every request kind, saturation and the
// order climb and restart; then random load, step, invalidate and spare passes
// run under a range of max_order settings. A local integrator predicts every
// result beat the table does not fix; both ports idle and stall in random bursts.
// ----------------------------------------------------------------------------
module adams_bashforth_stepper_unit_tb;
  import abs_pkg::*;

  localparam logic [1:0] REQ_SPARE    = 2'd3;
  localparam int         RANDOM_BEATS = 1200;
  localparam int         CALM_TAIL    = 1050;
  localparam int         LONG_HOLD    = 120;
  localparam longint     Q_MAX        = 64'sd2147483647;
  localparam longint     Q_MIN        = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] state;
    logic [3:0]         idx;
    logic               last;
    logic [2:0]         ord;
    logic               sat;
  } beat_t;

  typedef struct packed {
    logic [1:0]         req;
    logic [3:0]         idx;
    logic               last;
    logic signed [31:0] val;
    logic [31:0]        h;
    logic               typed;
    logic signed [31:0] state;
    logic [2:0]         ord;
    logic               sat;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = REQ_LOAD;
  logic [3:0]         element_index_i = '0;
  logic               last_element_i = 1'b0;
  logic signed [31:0] value_i = '0;
  logic [31:0]        step_size_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] state_value_o;
  logic [3:0]         out_index_o;
  logic               out_last_o;
  logic [2:0]         order_used_o;
  logic               saturated_o;

  logic signed [31:0] state_copy [STATE_DIM];
  logic signed [31:0] deriv_ring [HIST_DEPTH][STATE_DIM];
  bit                 state_known [STATE_DIM];
  bit                 deriv_known [HIST_DEPTH][STATE_DIM];
  logic [2:0]         cur_order = ORDER_ONE;
  logic [ROW_W-1:0]   ring_row = '0;
  logic [31:0]        prev_h = '0;
  logic [2:0]         max_ord = ORDER_RST;
  int                 ab_weight [4][4] = '{'{24, 0, 0, 0}, '{36, -12, 0, 0},
                                           '{46, -32, 10, 0}, '{55, -59, 37, -9}};

  beat_t              state_beats_due [$];
  int                 errors = 0;
  int                 issued = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int                 stall_left = 0;

  dir_row_t dir_rows [21] = '{
    '{REQ_LOAD,  4'd0,  1'b0, 32'sh7FFFFFFF, 32'h0,        1'b1, 32'sh7FFFFFFF, 3'd1, 1'b0},
    '{REQ_LOAD,  4'd15, 1'b1, 32'sh80000000, 32'hFFFFFFFF, 1'b1, 32'sh80000000, 3'd1, 1'b0},
    '{REQ_INVAL, 4'd3,  1'b0, 32'sh12345678, 32'h0,        1'b1, 32'sh0,        3'd1, 1'b0},
    '{REQ_SPARE, 4'd5,  1'b1, 32'shFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'sh0,        3'd1, 1'b0},
    '{REQ_STEP,  4'd0,  1'b0, 32'sh7FFFFFFF, 32'hFFFFFFFF, 1'b1, 32'sh7FFFFFFF, 3'd1, 1'b1},
    '{REQ_STEP,  4'd15, 1'b1, 32'sh80000000, 32'hFFFFFFFF, 1'b1, 32'sh80000000, 3'd1, 1'b1},
    '{REQ_SPARE, 4'd2,  1'b0, 32'sh0,        32'h0,        1'b1, 32'sh0,        3'd2, 1'b0},
    '{REQ_LOAD,  4'd1,  1'b0, 32'sh0,        32'h0,        1'b1, 32'sh0,        3'd2, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'sh00010000, 32'h00010000, 1'b1, 32'sh00010000, 3'd1, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'sh00020000, 32'h00010000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'shFFFF0000, 32'h00010000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'sh00008000, 32'h00010000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'sh00010000, 32'h00010000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd1,  1'b1, 32'sh00010000, 32'h00020000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_INVAL, 4'd0,  1'b1, 32'sh0,        32'h0,        1'b1, 32'sh0,        3'd1, 1'b0},
    '{REQ_STEP,  4'd1,  1'b0, 32'sh00030000, 32'h00020000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd0,  1'b1, 32'sh80000000, 32'h00020000, 1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd0,  1'b1, 32'sh0,        32'h0,        1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_STEP,  4'd0,  1'b1, 32'sh0,        32'h0,        1'b0, 32'sh0,        3'd0, 1'b0},
    '{REQ_LOAD,  4'd7,  1'b0, 32'sh00000001, 32'h0,        1'b1, 32'sh00000001, 3'd3, 1'b0},
    '{REQ_STEP,  4'd7,  1'b1, 32'sh7FFFFFFF, 32'h5,        1'b0, 32'sh0,        3'd0, 1'b0}
  };

  adams_bashforth_stepper_unit uut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [2:0] order_cap();
    logic [2:0] m;
    m = max_ord;
    if (m == 3'd0) m = ORDER_ONE;
    if (m > ORDER_TOP) m = ORDER_TOP;
    return m;
  endfunction

  function automatic logic [2:0] order_for(logic [31:0] h);
    logic [2:0] o;
    o = (h != prev_h) ? ORDER_ONE : cur_order;
    if (o > order_cap()) o = order_cap();
    return o;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 'h7FFFF)) - 'h40000;
      4, 5:       v = int'($urandom_range(0, 'h1FFFFFF)) - 'h1000000;
      6, 7:       v = $urandom();
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:    v = $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range('h100, 'h20000);
      5, 6:          return $urandom_range(0, 'hFFFF);
      7:             return $urandom();
      8:             return '0;
      default:       return 32'hFFFFFFFF;
    endcase
  endfunction

  // advance the local integrator by one beat and return the result it gives
  function automatic beat_t integrate_item(logic [1:0] req, logic [3:0] idx, logic last,
                                           logic signed [31:0] val, logic [31:0] h);
    beat_t              b;
    logic [2:0]         ord;
    logic [2:0]         lim;
    logic [ROW_W-1:0]   r;
    longint             acc;
    longint             nxt;
    longint unsigned    mag;
    longint unsigned    t;
    longint unsigned    q;
    b = '0;
    b.idx = idx;
    b.last = last;
    ord = cur_order;
    case (req)
      REQ_LOAD: begin
        state_copy[idx] = val;
        state_known[idx] = 1'b1;
        b.state = val;
      end
      REQ_STEP: begin
        lim = order_cap();
        ord = order_for(h);
        deriv_ring[ring_row][idx] = val;
        deriv_known[ring_row][idx] = 1'b1;
        acc = 0;
        for (int i = 0; i < ord; i++) begin
          r = ring_row - ROW_W'(i);
          acc += ab_weight[ord - 1][i] * longint'(deriv_ring[r][idx]);
        end
        mag = (acc < 0) ? -acc : acc;
        t = mag * h[31:16] + ((mag * h[15:0]) >> 16);
        q = t / 24;
        nxt = longint'(state_copy[idx]) + ((acc < 0) ? -longint'(q) : longint'(q));
        if (nxt > Q_MAX) begin
          nxt = Q_MAX;
          b.sat = 1'b1;
        end else if (nxt < Q_MIN) begin
          nxt = Q_MIN;
          b.sat = 1'b1;
        end
        state_copy[idx] = nxt[31:0];
        b.state = nxt[31:0];
        if (last) begin
          cur_order = (ord + 3'd1 > lim) ? lim : ord + 3'd1;
          ring_row = ring_row + 1'b1;
          prev_h = h;
        end
      end
      REQ_INVAL: begin
        cur_order = ORDER_ONE;
        prev_h = '0;
        ord = ORDER_ONE;
      end
      default: ;
    endcase
    b.ord = ord;
    return b;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] due);
    if (errors < 50) $display("mismatch on %s: got %0h, expected %0h", what, got, due);
    errors++;
  endtask

  task automatic send_beat(logic [1:0] req, logic [3:0] idx, logic last,
                           logic signed [31:0] val, logic [31:0] h, logic typed, beat_t want);
    beat_t b;
    b = integrate_item(req, idx, last, val, h);
    state_beats_due.push_back(typed ? want : b);
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    element_index_i <= idx;
    last_element_i  <= last;
    value_i         <= val;
    step_size_i     <= h;
    do @(posedge clk_i); while (in_stall_o);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // keep every step clear of unwritten state and history
  task automatic offer(logic [1:0] req, logic [3:0] idx, logic last,
                       logic signed [31:0] val, logic [31:0] h);
    bit         ready;
    logic [2:0] ord;
    if (req == REQ_STEP && !state_known[idx]) req = REQ_LOAD;
    if (req == REQ_STEP) begin
      ord = order_for(h);
      ready = 1'b1;
      for (int i = 1; i < ord; i++)
        if (!deriv_known[ring_row - ROW_W'(i)][idx]) ready = 1'b0;
      if (!ready) h = prev_h + 32'd1;
    end
    if (req != REQ_SPARE) issued++;
    send_beat(req, idx, last, val, h, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (state_beats_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_max_order(logic [2:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_ord = m;
    cur_order = ORDER_ONE;
    prev_h = '0;
  endtask

  always @(posedge clk_i) begin : result_port
    beat_t want;
    bit    hold;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (state_beats_due.size() == 0) begin
        report("unexpected beat", state_value_o, '0);
      end else begin
        want = state_beats_due.pop_front();
        if (state_value_o !== want.state) report("state_value", state_value_o, want.state);
        if (out_index_o !== want.idx)
          report("out_index", 32'(out_index_o), 32'(want.idx));
        if (out_last_o !== want.last)
          report("out_last", 32'(out_last_o), 32'(want.last));
        if (order_used_o !== want.ord)
          report("order_used", 32'(order_used_o), 32'(want.ord));
        if (saturated_o !== want.sat)
          report("saturated", 32'(saturated_o), 32'(want.sat));
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    hold = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      hold = 1'b1;
    end
    out_stall_i <= hold;
  end

  initial begin : stimulus
    logic [2:0]  plan [8];
    logic [31:0] h_run;
    beat_t       want;
    int          kind;
    int          first;
    int          n;
    int          ph;
    plan = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      want = '{dir_rows[k].state, dir_rows[k].idx, dir_rows[k].last,
               dir_rows[k].ord, dir_rows[k].sat};
      send_beat(dir_rows[k].req, dir_rows[k].idx, dir_rows[k].last, dir_rows[k].val,
                dir_rows[k].h, dir_rows[k].typed, want);
    end
    settle();

    for (int e = 0; e < STATE_DIM; e++)
      offer(REQ_LOAD, 4'(e), e == STATE_DIM - 1, pick_value(), '0);
    h_run = pick_step();
    ph = 0;
    while (issued < RANDOM_BEATS) begin
      settle();
      write_max_order(ph < 8 ? plan[ph] : 3'($urandom_range(0, 7)));
      calm = (issued >= CALM_TAIL) || ($urandom_range(0, 3) == 0);
      if (ph == 2) hold_req = 1'b1;
      repeat ($urandom_range(4, 12)) begin
        kind  = $urandom_range(0, 99);
        first = $urandom_range(0, STATE_DIM - 1);
        n     = $urandom_range(1, STATE_DIM - first);
        if (kind < 60) begin
          if ($urandom_range(0, 4) == 0) h_run = pick_step();
          for (int e = 0; e < n; e++)
            offer(REQ_STEP, 4'(first + e), e == n - 1, pick_value(), h_run);
        end else if (kind < 75) begin
          for (int e = 0; e < n; e++)
            offer(REQ_LOAD, 4'(first + e), e == n - 1, pick_value(), h_run);
        end else if (kind < 82) begin
          offer(REQ_INVAL, 4'(first), 1'($urandom_range(0, 1)), $urandom(), $urandom());
        end else if (kind < 86) begin
          offer(REQ_SPARE, 4'(first), 1'($urandom_range(0, 1)), $urandom(), $urandom());
        end else begin
          repeat ($urandom_range(1, 4))
            offer(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), pick_value(),
                  $urandom_range(0, 1) ? h_run : pick_step());
        end
        if (issued >= CALM_TAIL) calm = 1'b1;
      end
      ph++;
    end

    settle();
    repeat (24) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
